@@ sv/pbenc_pkg.sv @@
// Package with the shared types, codes and the value mapping of the scalar field encoder.
package pbenc_pkg;

   localparam int PBENC_COUNT_WIDTH = 16;

   localparam int CAP_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int DIGIT_W    = 7;
   localparam int TYPE_W     = 4;
   localparam int NUMBER_W   = 29;
   localparam int VALUE_W    = 64;
   localparam int WIRE_W     = 3;
   localparam int KEY_W      = NUMBER_W + WIRE_W;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 24;
   localparam int NEED_W     = 4;

   localparam logic [NEED_W-1:0] FIX32_BYTES = 4'd4;
   localparam logic [NEED_W-1:0] FIX64_BYTES = 4'd8;
   localparam logic [NEED_W-1:0] ONE_BYTE    = 4'd1;

   // Field type codes.
   localparam logic [TYPE_W-1:0] FT_DOUBLE   = 4'd0;
   localparam logic [TYPE_W-1:0] FT_FLOAT    = 4'd1;
   localparam logic [TYPE_W-1:0] FT_INT32    = 4'd2;
   localparam logic [TYPE_W-1:0] FT_UINT32   = 4'd3;
   localparam logic [TYPE_W-1:0] FT_SINT32   = 4'd4;
   localparam logic [TYPE_W-1:0] FT_INT64    = 4'd5;
   localparam logic [TYPE_W-1:0] FT_UINT64   = 4'd6;
   localparam logic [TYPE_W-1:0] FT_SINT64   = 4'd7;
   localparam logic [TYPE_W-1:0] FT_FIXED32  = 4'd8;
   localparam logic [TYPE_W-1:0] FT_FIXED64  = 4'd9;
   localparam logic [TYPE_W-1:0] FT_SFIXED32 = 4'd10;
   localparam logic [TYPE_W-1:0] FT_SFIXED64 = 4'd11;
   localparam logic [TYPE_W-1:0] FT_BOOL     = 4'd12;
   localparam logic [TYPE_W-1:0] FT_ENUM     = 4'd13;

   // Wire types.
   localparam logic [WIRE_W-1:0] WIRE_VARINT  = 3'd0;
   localparam logic [WIRE_W-1:0] WIRE_FIXED64 = 3'd1;
   localparam logic [WIRE_W-1:0] WIRE_FIXED32 = 3'd5;

   typedef struct packed {
      logic              clear;
      logic              incr;
      logic [NEED_W-1:0] need;
   } cnt_cmd_type;

   typedef struct packed {
      logic             room_ok;
      logic [CAP_W-1:0] used_cur;
      logic [CAP_W-1:0] used_inc;
   } cnt_stat_type;

   typedef struct packed {
      logic [WIRE_W-1:0]  wt;
      logic [VALUE_W-1:0] val;
   } mapped_type;

   // Wire type and the 64-bit value that goes on the wire for one field type.
   function automatic mapped_type pbenc_map(input logic [TYPE_W-1:0]  ftype,
                                            input logic [VALUE_W-1:0] raw);
      mapped_type  m;
      logic [31:0] lo;
      logic        s32;
      lo    = raw[31:0];
      s32   = lo[31];
      m.wt  = WIRE_VARINT;
      m.val = raw;
      case (ftype)
         FT_DOUBLE, FT_FIXED64, FT_SFIXED64: begin
            m.wt  = WIRE_FIXED64;
            m.val = raw;
         end
         FT_FLOAT, FT_FIXED32, FT_SFIXED32: begin
            m.wt  = WIRE_FIXED32;
            m.val = {32'd0, lo};
         end
         FT_INT32, FT_ENUM: m.val = {{32{s32}}, lo};
         FT_UINT32:         m.val = {32'd0, lo};
         FT_SINT32:         m.val = {32'd0, {lo[30:0], 1'b0} ^ {32{s32}}};
         FT_SINT64:         m.val = {raw[62:0], 1'b0} ^ {VALUE_W{raw[63]}};
         FT_BOOL:           m.val = {63'd0, |lo};
         default:           m.val = raw;
      endcase
      return m;
   endfunction

endpackage

@@ sv/pbenc_count.sv @@
// Byte counter of the current message, buffer limit register and room check.
module pbenc_count
   import pbenc_pkg::*;
#(
   parameter int COUNT_WIDTH = PBENC_COUNT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data,
   input  cnt_cmd_type      cmd,
   output cnt_stat_type     stat
);

   localparam int EXT_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;
   localparam int LIM_W = EXT_W + 1;
   localparam logic [EXT_W-1:0] CMAX = EXT_W'({COUNT_WIDTH{1'b1}});
   localparam logic [EXT_W-1:0] CAP_RESET = EXT_W'({CAP_W{1'b1}});
   localparam logic [EXT_W-1:0] LIM_RESET = (CAP_RESET < CMAX) ? CAP_RESET : CMAX;

   logic [COUNT_WIDTH-1:0] used_ff, used_in, used_plus;
   logic [EXT_W-1:0]       limit_ff, limit_in, cap_ext;
   logic [EXT_W-1:0]       used_ext, plus_ext;

   assign csr_ready = 1'b1;

   // The usable limit is kept already clipped to what the counter can hold.
   assign cap_ext   = EXT_W'(csr_data);
   assign limit_in  = (csr_valid) ? ((cap_ext < CMAX) ? cap_ext : CMAX) : limit_ff;

   assign used_plus = used_ff + COUNT_WIDTH'(1);
   assign used_in   = cmd.clear ? '0 : (cmd.incr ? used_plus : used_ff);
   assign used_ext  = EXT_W'(used_ff);
   assign plus_ext  = EXT_W'(used_plus);

   assign stat.room_ok  = (LIM_W'(used_ext) + LIM_W'(cmd.need)) <= LIM_W'(limit_ff);
   assign stat.used_cur = used_ext[CAP_W-1:0];
   assign stat.used_inc = plus_ext[CAP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         limit_ff <= LIM_RESET;
      end else begin
         used_ff  <= used_in;
         limit_ff <= limit_in;
      end
   end

endmodule

@@ sv/protobuf_scalar_field_encoder_top.sv @@
// Top level of the protobuf scalar field encoder: sequencer, digit shift registers, output stage.
//
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_tvalid/req_tready | tdata type,number,value; tuser kind,packed
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata byte,count; tuser valid,status; tlast
//  csr     | in        | csr_valid/csr_ready   | csr_data buffer capacity
//
// A field transaction first loads the shift registers and then gives one result per
// wire byte: up to five key bytes and up to ten value bytes.
// The rate is set by the output register, which moves one wire byte per cycle unless rsp stalls.
// A start-of-message transaction passes through the clear state. Reset is synchronous and clears the
// byte count and restores the full capacity. A stalled rsp side freezes the sequencer outside idle.
module protobuf_scalar_field_encoder_top
   import pbenc_pkg::*;
#(
   parameter int COUNT_WIDTH = PBENC_COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // field_type [3:0], field_number [32:4], field_value [96:33], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind [0], packed_element [1]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_byte [7:0], bytes_used_now [23:8]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // byte_valid [0], status [1]
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CLR  = 2'd1;
   localparam logic [1:0] S_KEY  = 2'd2;
   localparam logic [1:0] S_VAL  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [KEY_W-1:0]   key_sr_ff, key_sr_in;
   logic [VALUE_W-1:0] val_sr_ff, val_sr_in;
   logic               fixed_ff, fixed_in;
   logic               fix64_ff, fix64_in;
   logic               fix_first_ff, fix_first_in;
   logic [2:0]         fix_left_ff, fix_left_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [CAP_W-1:0]   rsp_used_ff, rsp_used_in;

   logic               advance;
   logic               cnt_clear, cnt_incr;
   logic [NEED_W-1:0]  cnt_need;
   cnt_cmd_type        cnt_cmd;
   cnt_stat_type       cnt_stat;
   mapped_type         mapped;

   pbenc_count #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cnt_cmd),
      .stat      (cnt_stat)
   );

   // A new item is taken only between fields; a waiting result does not block it.
   assign req_tready = (state_ff == S_IDLE);
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign mapped     = pbenc_map(req_tdata[3:0], req_tdata[96:33]);

   // A fixed value needs room for all of its bytes before the first one goes out.
   assign cnt_need = (state_ff == S_VAL && fixed_ff && fix_first_ff) ?
                     (fix64_ff ? FIX64_BYTES : FIX32_BYTES) : ONE_BYTE;
   assign cnt_cmd  = '{clear: cnt_clear, incr: cnt_incr, need: cnt_need};

   always_comb begin
      state_in      = state_ff;
      key_sr_in     = key_sr_ff;
      val_sr_in     = val_sr_ff;
      fixed_in      = fixed_ff;
      fix64_in      = fix64_ff;
      fix_first_in  = fix_first_ff;
      fix_left_in   = fix_left_ff;
      cnt_clear     = 1'b0;
      cnt_incr      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_sr_in    = {req_tdata[32:4], mapped.wt};
               val_sr_in    = mapped.val;
               fixed_in     = (mapped.wt != WIRE_VARINT);
               fix64_in     = (mapped.wt == WIRE_FIXED64);
               fix_first_in = 1'b1;
               fix_left_in  = (mapped.wt == WIRE_FIXED64) ? 3'd7 : 3'd3;
               if (req_tuser[0]) begin
                  state_in = S_CLR;
               end else if (req_tuser[1]) begin
                  state_in = S_VAL;
               end else begin
                  state_in = S_KEY;
               end
            end
         end
         S_CLR: begin
            if (advance) begin
               cnt_clear     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_bvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_status_in = 1'b0;
               rsp_used_in   = '0;
               state_in      = S_IDLE;
            end
         end
         S_KEY, S_VAL: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               if (!cnt_stat.room_ok) begin
                  // Buffer is full: close the transaction with an error item.
                  rsp_byte_in   = '0;
                  rsp_bvalid_in = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = 1'b1;
                  rsp_used_in   = cnt_stat.used_cur;
                  state_in      = S_IDLE;
               end else begin
                  cnt_incr      = 1'b1;
                  rsp_bvalid_in = 1'b1;
                  rsp_status_in = 1'b0;
                  rsp_used_in   = cnt_stat.used_inc;
                  if (state_ff == S_KEY) begin
                     rsp_byte_in = {|key_sr_ff[KEY_W-1:DIGIT_W], key_sr_ff[DIGIT_W-1:0]};
                     rsp_last_in = 1'b0;
                     key_sr_in   = key_sr_ff >> DIGIT_W;
                     if (key_sr_ff[KEY_W-1:DIGIT_W] == '0) begin
                        state_in = S_VAL;
                     end
                  end else if (fixed_ff) begin
                     rsp_byte_in  = val_sr_ff[BYTE_W-1:0];
                     rsp_last_in  = (fix_left_ff == 3'd0);
                     val_sr_in    = val_sr_ff >> BYTE_W;
                     fix_first_in = 1'b0;
                     fix_left_in  = fix_left_ff - 3'd1;
                     if (fix_left_ff == 3'd0) begin
                        state_in = S_IDLE;
                     end
                  end else begin
                     rsp_byte_in = {|val_sr_ff[VALUE_W-1:DIGIT_W], val_sr_ff[DIGIT_W-1:0]};
                     rsp_last_in = (val_sr_ff[VALUE_W-1:DIGIT_W] == '0);
                     val_sr_in   = val_sr_ff >> DIGIT_W;
                     if (val_sr_ff[VALUE_W-1:DIGIT_W] == '0) begin
                        state_in = S_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_sr_ff     <= key_sr_in;
      val_sr_ff     <= val_sr_in;
      fixed_ff      <= fixed_in;
      fix64_ff      <= fix64_in;
      fix_first_ff  <= fix_first_in;
      fix_left_ff   <= fix_left_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_used_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_bvalid_ff};
   assign rsp_tlast  = rsp_last_ff;

   // An error item carries no byte and always ends its transaction.
   a_status_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tlast && !rsp_tuser[0]))
      else $error("error item without last or with a byte");

   // A start-of-message item reports an empty message.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && !rsp_tuser[0] && !rsp_tuser[1]) |->
      (rsp_tdata[23:8] == '0))
      else $error("start-of-message item with nonzero byte count");

   // A key byte is never the final byte of a field.
   a_key_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEY && advance) |=> !(rsp_tlast && rsp_tuser[0]))
      else $error("key byte closed a field");

endmodule
